>>> hdl/slcpp_pkg.sv
// Shared types and constants for the sync, length and checksum packet parser.
package slcpp_pkg;

	localparam int DATA_W = 8;
	localparam int IDX_W  = 9;
	localparam int SUM_W  = 16;
	localparam int RUN_W  = 24;
	localparam int ERR_W  = 32;
	localparam int CFG_W  = 16;
	localparam int CIDX_W = 2;

	typedef enum logic [2:0] {
		PH_SYNC1 = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_COUNT = 3'd2,
		PH_ID    = 3'd3,
		PH_SUMLO = 3'd4,
		PH_SUMHI = 3'd5,
		PH_DATA  = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE            = 3'd0,
		EV_BAD_FIRST_SYNC  = 3'd1,
		EV_BAD_SECOND_SYNC = 3'd2,
		EV_BAD_SUM         = 3'd3,
		EV_ACCEPT          = 3'd4
	} event_t;

	localparam logic REQ_FEED = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam logic [CIDX_W-1:0] CFG_FIRST_SYNC  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_SECOND_SYNC = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_SYNC_WORD   = 2'd2;

	typedef struct packed {
		logic [DATA_W-1:0] first_sync;
		logic [DATA_W-1:0] second_sync;
		logic [SUM_W-1:0]  sync_word;
	} cfg_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} wr_t;

	typedef struct packed {
		event_t            event_code;
		logic [DATA_W-1:0] message_id;
		logic              held_valid;
		logic [IDX_W-1:0]  held_length;
		logic [ERR_W-1:0]  first_sync_errors;
		logic [ERR_W-1:0]  second_sync_errors;
		logic [ERR_W-1:0]  sum_errors;
	} status_t;

endpackage

>>> hdl/slcpp_core.sv
// Parse state machine, checksum accumulator and error counters of the packet parser.
module slcpp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              feed,
	input  logic [7:0]        data_byte,
	input  slcpp_pkg::cfg_t   cfg,
	output slcpp_pkg::status_t status,
	output slcpp_pkg::wr_t    wr
);
	import slcpp_pkg::*;

	phase_t            phase_q, phase_d;
	logic [DATA_W-1:0] count_q, count_d;
	logic [DATA_W-1:0] id_q, id_d;
	logic [SUM_W-1:0]  exp_q, exp_d;
	logic [IDX_W-1:0]  bytes_q, bytes_d;
	logic [RUN_W-1:0]  run_q, run_d;
	logic              held_valid_q, held_valid_d;
	logic [IDX_W-1:0]  held_len_q, held_len_d;
	logic [ERR_W-1:0]  err1_q, err1_d;
	logic [ERR_W-1:0]  err2_q, err2_d;
	logic [ERR_W-1:0]  errs_q, errs_d;
	event_t            event_d;

	logic [RUN_W-1:0]  run_new;
	logic [IDX_W-1:0]  bytes_new;
	logic [IDX_W-1:0]  need;
	logic [RUN_W:0]    total;
	logic [SUM_W-1:0]  fold;

	assign run_new   = run_q + (bytes_q[0] ? {8'b0, data_byte, 8'b0} : {16'b0, data_byte});
	assign bytes_new = bytes_q + 9'd1;
	assign need      = {count_q, 1'b0};
	assign total     = {1'b0, run_new} + {9'b0, cfg.sync_word};
	assign fold      = total[SUM_W-1:0] + {7'b0, total[RUN_W:SUM_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SYNC1;
			count_q      <= '0;
			id_q         <= '0;
			exp_q        <= '0;
			bytes_q      <= '0;
			run_q        <= '0;
			held_valid_q <= 1'b0;
			held_len_q   <= '0;
			err1_q       <= '0;
			err2_q       <= '0;
			errs_q       <= '0;
		end else begin
			phase_q      <= phase_d;
			count_q      <= count_d;
			id_q         <= id_d;
			exp_q        <= exp_d;
			bytes_q      <= bytes_d;
			run_q        <= run_d;
			held_valid_q <= held_valid_d;
			held_len_q   <= held_len_d;
			err1_q       <= err1_d;
			err2_q       <= err2_d;
			errs_q       <= errs_d;
		end
	end

	always_comb begin
		phase_d      = phase_q;
		count_d      = count_q;
		id_d         = id_q;
		exp_d        = exp_q;
		bytes_d      = bytes_q;
		run_d        = run_q;
		held_valid_d = held_valid_q;
		held_len_d   = held_len_q;
		err1_d       = err1_q;
		err2_d       = err2_q;
		errs_d       = errs_q;
		event_d      = EV_NONE;
		wr.en        = 1'b0;
		wr.addr      = bytes_q;
		if (feed) begin
			case (phase_q)
				PH_SYNC2: begin
					if (data_byte != cfg.second_sync) begin
						err2_d  = err2_q + 32'd1;
						event_d = EV_BAD_SECOND_SYNC;
						phase_d = PH_SYNC1;
						count_d = '0;
						exp_d   = '0;
						bytes_d = '0;
						run_d   = '0;
					end else begin
						phase_d = PH_COUNT;
					end
				end
				PH_COUNT: begin
					count_d = data_byte;
					phase_d = PH_ID;
				end
				PH_ID: begin
					id_d    = data_byte;
					phase_d = PH_SUMLO;
				end
				PH_SUMLO: begin
					exp_d   = {8'b0, data_byte};
					phase_d = PH_SUMHI;
				end
				PH_SUMHI: begin
					held_valid_d = 1'b0;
					held_len_d   = '0;
					if (count_q == '0) begin
						held_valid_d = 1'b1;
						event_d      = EV_ACCEPT;
						phase_d      = PH_SYNC1;
						count_d      = '0;
						exp_d        = '0;
						bytes_d      = '0;
						run_d        = '0;
					end else begin
						// The length and id word is folded into the running sum up front.
						exp_d   = {data_byte, exp_q[7:0]};
						bytes_d = '0;
						run_d   = {8'b0, id_q, count_q};
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					wr.en = 1'b1;
					if (bytes_new == need) begin
						if (fold != exp_q) begin
							errs_d  = errs_q + 32'd1;
							event_d = EV_BAD_SUM;
						end else begin
							held_valid_d = 1'b1;
							held_len_d   = need;
							event_d      = EV_ACCEPT;
						end
						phase_d = PH_SYNC1;
						count_d = '0;
						exp_d   = '0;
						bytes_d = '0;
						run_d   = '0;
					end else begin
						run_d   = run_new;
						bytes_d = bytes_new;
					end
				end
				default: begin
					if (data_byte != cfg.first_sync) begin
						err1_d  = err1_q + 32'd1;
						event_d = EV_BAD_FIRST_SYNC;
						phase_d = PH_SYNC1;
						count_d = '0;
						exp_d   = '0;
						bytes_d = '0;
						run_d   = '0;
					end else begin
						phase_d = PH_SYNC2;
					end
				end
			endcase
		end
	end

	always_comb begin
		status.event_code         = event_d;
		status.message_id         = id_d;
		status.held_valid         = held_valid_d;
		status.held_length        = held_len_d;
		status.first_sync_errors  = err1_d;
		status.second_sync_errors = err2_d;
		status.sum_errors         = errs_d;
	end

endmodule

>>> hdl/sync_length_checksum_packet_parser.sv
// Top level of the sync, length and checksum packet parser with its payload store.
// A transaction is registered in the input register, its result in the result register.
// Throughput: one transaction per cycle when out_stall is low; the input register and the
// result register are separated so a new transaction enters while a finished result waits.
// Reset clears the parse state, the held packet, the error counters and the configuration.
// The payload store is not cleared; only bytes of the held packet are ever returned.
module sync_length_checksum_packet_parser #(
	parameter int PAYLOAD_BYTES = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [slcpp_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [slcpp_pkg::CFG_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [slcpp_pkg::DATA_W-1:0]  data_byte,
	input  logic [slcpp_pkg::IDX_W-1:0]   read_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    event_code,
	output logic [slcpp_pkg::DATA_W-1:0]  message_id,
	output logic                          packet_valid,
	output logic [slcpp_pkg::IDX_W-1:0]   valid_byte_count,
	output logic [slcpp_pkg::DATA_W-1:0]  read_data,
	output logic                          read_ok,
	output logic [slcpp_pkg::ERR_W-1:0]   bad_first_sync_count,
	output logic [slcpp_pkg::ERR_W-1:0]   bad_second_sync_count,
	output logic [slcpp_pkg::ERR_W-1:0]   bad_sum_count
);
	import slcpp_pkg::*;

	localparam int ADDR_W = $clog2(PAYLOAD_BYTES);

	cfg_t              cfg_q;
	status_t           status;
	wr_t               wr;

	logic              out_ready;
	logic              accept;
	logic              commit;
	logic              feed;
	logic              wr_en;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic              read_ok_d;

	logic              valid_s1;
	logic              req_type_s1;
	logic [DATA_W-1:0] data_byte_s1;
	logic [IDX_W-1:0]  read_index_s1;
	logic [DATA_W-1:0] mem_data_s1;
	logic              byp_s1;
	logic [DATA_W-1:0] byp_data_s1;

	logic              out_valid_q;
	event_t            event_code_q;
	logic [DATA_W-1:0] message_id_q;
	logic              packet_valid_q;
	logic [IDX_W-1:0]  valid_byte_count_q;
	logic [DATA_W-1:0] read_data_q;
	logic              read_ok_q;
	logic [ERR_W-1:0]  err1_q;
	logic [ERR_W-1:0]  err2_q;
	logic [ERR_W-1:0]  errs_q;

	logic [DATA_W-1:0] mem [PAYLOAD_BYTES];

	assign out_ready = !out_valid_q || !out_stall;
	assign commit    = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign accept    = in_valid && !in_stall;
	assign feed      = commit && (req_type_s1 == REQ_FEED);

	assign waddr = ADDR_W'(wr.addr);
	assign raddr = ADDR_W'(read_index);
	assign wr_en = wr.en && ({1'b0, waddr} < (ADDR_W+1)'(PAYLOAD_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_SYNC:  cfg_q.first_sync  <= cfg_data[DATA_W-1:0];
				CFG_SECOND_SYNC: cfg_q.second_sync <= cfg_data[DATA_W-1:0];
				CFG_SYNC_WORD:   cfg_q.sync_word   <= cfg_data[SUM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	slcpp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed      (feed),
		.data_byte (data_byte_s1),
		.cfg       (cfg_q),
		.status    (status),
		.wr        (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1   <= req_type;
			data_byte_s1  <= data_byte;
			read_index_s1 <= read_index;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= data_byte_s1;
		end
	end

	// A byte written by the committing transaction is forwarded to a read entering alongside it.
	always_ff @(posedge clk) begin
		if (accept) begin
			mem_data_s1 <= mem[raddr];
			byp_s1      <= wr_en && (waddr == raddr);
			byp_data_s1 <= data_byte_s1;
		end
	end

	assign read_ok_d = (req_type_s1 == REQ_READ) && status.held_valid &&
		(read_index_s1 < status.held_length) &&
		({1'b0, ADDR_W'(read_index_s1)} < (ADDR_W+1)'(PAYLOAD_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			event_code_q       <= status.event_code;
			message_id_q       <= status.message_id;
			packet_valid_q     <= status.held_valid;
			valid_byte_count_q <= status.held_valid ? status.held_length : '0;
			read_ok_q          <= read_ok_d;
			read_data_q        <= read_ok_d ? (byp_s1 ? byp_data_s1 : mem_data_s1) : '0;
			err1_q             <= status.first_sync_errors;
			err2_q             <= status.second_sync_errors;
			errs_q             <= status.sum_errors;
		end
	end

	assign out_valid             = out_valid_q;
	assign event_code            = event_code_q;
	assign message_id            = message_id_q;
	assign packet_valid          = packet_valid_q;
	assign valid_byte_count      = valid_byte_count_q;
	assign read_data             = read_data_q;
	assign read_ok               = read_ok_q;
	assign bad_first_sync_count  = err1_q;
	assign bad_second_sync_count = err2_q;
	assign bad_sum_count         = errs_q;

endmodule
